[rtl/core/wspid_pkg.sv]
// Shared types, widths and constants of the wheel speed PID controller.
`default_nettype none

package wspid_pkg;

    // Fraction bits of every speed and error value (Q.F)
    localparam int SPEED_FRAC_BITS = 8;

    // Field widths
    localparam int COUNT_W  = 16;
    localparam int TARGET_W = 16;
    localparam int SPEED_W  = 24;
    localparam int ERR_W    = 26;
    localparam int DRIVE_W  = 16;

    // Configuration register widths
    localparam int CG_W   = 16;
    localparam int SLEW_W = 10;
    localparam int CAP_W  = 10;
    localparam int GAIN_W = 16;
    localparam int CUT_W  = 12;
    localparam int LIM_W  = 15;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Shared multiplier: signed A (a wheel count, the error or a difference of the error) by signed B
    localparam int MUL_A_W = ERR_W + 2;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // PID sum holds three products
    localparam int SUM_W = MUL_P_W + 2;

    // Scaled count before saturation, room for shifts up to 4 bits
    localparam int SCALE_W = MUL_P_W + 4;

    // Slew and cap comparisons
    localparam int CMP_W = ((SPEED_W > SLEW_W + SPEED_FRAC_BITS) ?
                            SPEED_W : SLEW_W + SPEED_FRAC_BITS) + 2;

    // Error calculation before saturation
    localparam int EC_W = ((TARGET_W + SPEED_FRAC_BITS > SPEED_W) ?
                           TARGET_W + SPEED_FRAC_BITS : SPEED_W) + 2;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
    localparam logic signed [ERR_W-1:0]   ERR_MAX   = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0]   ERR_MIN   = {1'b1, {(ERR_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNT_GAIN      = 3'd0,
        REG_SLEW_LIMIT      = 3'd1,
        REG_SPEED_CAP       = 3'd2,
        REG_GAIN_P          = 3'd3,
        REG_GAIN_I          = 3'd4,
        REG_GAIN_D          = 3'd5,
        REG_INTEGRAL_CUTOFF = 3'd6,
        REG_DRIVE_LIMIT     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [CG_W-1:0]   count_gain;
        logic [SLEW_W-1:0] slew_limit;
        logic [CAP_W-1:0]  speed_cap;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [CUT_W-1:0]  integral_cutoff;
        logic [LIM_W-1:0]  drive_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        count_gain:      16'd277,
        slew_limit:      10'd50,
        speed_cap:       10'd350,
        gain_p:          16'd1280,
        gain_i:          16'd38,
        gain_d:          16'd0,
        integral_cutoff: 12'd200,
        drive_limit:     15'd800
    };

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_SPD_R,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_DRIVE
    } state_t;

    // Operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        OP_LEFT,
        OP_RIGHT,
        OP_P,
        OP_I,
        OP_D
    } opsel_t;

    // Datapath controls from the sequencer
    typedef struct packed {
        logic   load_in;
        logic   mul_en;
        opsel_t op;
        logic   spd_en;
        logic   spd_right;
        logic   err_en;
        logic   sum_load;
        logic   sum_add;
        logic   sum_cut;
        logic   commit;
    } ctrl_t;

endpackage

`default_nettype wire

[rtl/core/wspid_if.sv]
// Channel interfaces of the wheel speed PID controller: sample, result, configuration.
`default_nettype none

interface wspid_in_if
    import wspid_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [COUNT_W-1:0]  left_count;
    logic signed [COUNT_W-1:0]  right_count;
    logic        [TARGET_W-1:0] target_speed;

    modport source (output valid, output left_count, output right_count,
                    output target_speed, input ready);
    modport sink   (input valid, input left_count, input right_count,
                    input target_speed, output ready);
endinterface

interface wspid_out_if
    import wspid_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;
    logic signed [SPEED_W-1:0] average_speed;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;

    modport source (output valid, output drive, output average_speed,
                    output left_speed, output right_speed, input ready);
    modport sink   (input valid, input drive, input average_speed,
                    input left_speed, input right_speed, output ready);
endinterface

interface wspid_cfg_if
    import wspid_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/wspid_cfg.sv]
// Configuration register file of the wheel speed PID controller.
`default_nettype none

module wspid_cfg
    import wspid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    wspid_cfg_if.sink   cfg,
    output cfg_t        regs
);

    cfg_t regs_reg;

    // Always take a write transfer
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Update the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= CFG_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_COUNT_GAIN:      regs_reg.count_gain      <= cfg.data[CG_W-1:0];
                REG_SLEW_LIMIT:      regs_reg.slew_limit      <= cfg.data[SLEW_W-1:0];
                REG_SPEED_CAP:       regs_reg.speed_cap       <= cfg.data[CAP_W-1:0];
                REG_GAIN_P:          regs_reg.gain_p          <= cfg.data[GAIN_W-1:0];
                REG_GAIN_I:          regs_reg.gain_i          <= cfg.data[GAIN_W-1:0];
                REG_GAIN_D:          regs_reg.gain_d          <= cfg.data[GAIN_W-1:0];
                REG_INTEGRAL_CUTOFF: regs_reg.integral_cutoff <= cfg.data[CUT_W-1:0];
                REG_DRIVE_LIMIT:     regs_reg.drive_limit     <= cfg.data[LIM_W-1:0];
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/wspid_mul.sv]
// Shared signed multiplier with registered product.
`default_nettype none

module wspid_mul
    import wspid_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    // Capture the product when the sequencer issues an operation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[rtl/core/wspid_seq.sv]
// Sequencer that steps one control tick through the shared multiplier.
`default_nettype none

module wspid_seq
    import wspid_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  out_busy,
    output logic  in_ready,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath controls
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctrl       = '0;
        ctrl.op    = OP_LEFT;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load_in = 1'b1;
                    state_next   = ST_MUL_L;
                end
            end
            ST_MUL_L:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.op     = OP_LEFT;
                state_next  = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.op     = OP_RIGHT;
                ctrl.spd_en = 1'b1;
                state_next  = ST_SPD_R;
            end
            ST_SPD_R:
            begin
                ctrl.spd_en    = 1'b1;
                ctrl.spd_right = 1'b1;
                state_next     = ST_ERR;
            end
            ST_ERR:
            begin
                ctrl.err_en = 1'b1;
                state_next  = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.op     = OP_P;
                state_next  = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.op       = OP_I;
                ctrl.sum_load = 1'b1;
                state_next    = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.op      = OP_D;
                ctrl.sum_add = 1'b1;
                ctrl.sum_cut = 1'b1;
                state_next   = ST_ACC;
            end
            ST_ACC:
            begin
                ctrl.sum_add = 1'b1;
                state_next   = ST_DRIVE;
            end
            ST_DRIVE:
            begin
                // Hold until the output register is free
                if (!out_busy)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/wheel_speed_incremental_pid.sv]
// Top level of the wheel speed incremental PID controller.
`default_nettype none

// Each control tick takes one sample transfer (left and right encoder counts and
// a target speed) and returns one result transfer (drive, average, left and right
// speeds). The block works on one tick at a time: a result is presented once the tick
// has passed through the sequencer steps, and the sample port is ready again in that
// same cycle, so the next sample transfer can follow at once. This holds provided
// the previous result has been taken by then; otherwise the tick waits in the final
// step until the output register frees up. The pace of the block is set
// by one 28x17 signed multiplier that is used five times per tick (two count
// scalings and the P, I and D products), with the speed, error and accumulation
// steps between. Configuration writes are taken in any cycle and must only be
// issued while no tick is in flight and no result is waiting.
module wheel_speed_incremental_pid
    import wspid_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    wspid_in_if.sink      sample,
    wspid_out_if.source   result,
    wspid_cfg_if.sink     cfg
);

    localparam int UP_SH  = (SPEED_FRAC_BITS >= 8) ? SPEED_FRAC_BITS - 8 : 0;
    localparam int DN_SH  = (SPEED_FRAC_BITS >= 8) ? 0 : 8 - SPEED_FRAC_BITS;
    localparam int INC_SH = SPEED_FRAC_BITS + 8;

    cfg_t  cfg_q;
    ctrl_t ctrl;
    logic  out_valid_reg;
    logic  out_busy;

    // Sample payload
    logic signed [COUNT_W-1:0]  left_reg;
    logic signed [COUNT_W-1:0]  right_reg;
    logic        [TARGET_W-1:0] tgt_reg;

    // Controller state
    logic signed [SPEED_W-1:0] left_prev_reg;
    logic signed [SPEED_W-1:0] right_prev_reg;
    logic signed [ERR_W-1:0]   last_err_reg;
    logic signed [ERR_W-1:0]   prior_err_reg;
    logic signed [DRIVE_W-1:0] accum_reg;

    // Per-tick working registers
    logic signed [SPEED_W-1:0] ls_reg;
    logic signed [SPEED_W-1:0] rs_reg;
    logic signed [SPEED_W-1:0] avg_reg;
    logic signed [ERR_W-1:0]   e_reg;
    logic signed [SUM_W-1:0]   sum_reg;

    // Output register
    logic signed [DRIVE_W-1:0] drive_out_reg;
    logic signed [SPEED_W-1:0] avg_out_reg;
    logic signed [SPEED_W-1:0] ls_out_reg;
    logic signed [SPEED_W-1:0] rs_out_reg;

    wspid_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_q)
    );

    assign out_busy = out_valid_reg && !result.ready;

    wspid_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .out_busy (out_busy),
        .in_ready (sample.ready),
        .ctrl     (ctrl)
    );

    // Capture the sample on its transfer
    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            left_reg  <= sample.left_count;
            right_reg <= sample.right_count;
            tgt_reg   <= sample.target_speed;
        end
    end

    // Select multiplier operands
    logic signed [COUNT_W:0]      left_neg;
    logic signed [MUL_A_W-1:0]    err_d1;
    logic signed [MUL_A_W-1:0]    err_d2;
    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [MUL_P_W-1:0]    prod;

    assign left_neg = -((COUNT_W+1)'(left_reg));
    assign err_d1   = MUL_A_W'(e_reg) - MUL_A_W'(last_err_reg);
    assign err_d2   = MUL_A_W'(e_reg) - (MUL_A_W'(last_err_reg) <<< 1)
                    + MUL_A_W'(prior_err_reg);

    always_comb
    begin
        unique case (ctrl.op)
            OP_LEFT:
            begin
                mul_a = MUL_A_W'(left_neg);
                mul_b = MUL_B_W'(cfg_q.count_gain);
            end
            OP_RIGHT:
            begin
                mul_a = MUL_A_W'(right_reg);
                mul_b = MUL_B_W'(cfg_q.count_gain);
            end
            OP_P:
            begin
                mul_a = err_d1;
                mul_b = MUL_B_W'(cfg_q.gain_p);
            end
            OP_I:
            begin
                mul_a = MUL_A_W'(e_reg);
                mul_b = MUL_B_W'(cfg_q.gain_i);
            end
            OP_D:
            begin
                mul_a = err_d2;
                mul_b = MUL_B_W'(cfg_q.gain_d);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    wspid_mul u_mul
    (
        .clk  (clk),
        .en   (ctrl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Speed unit: scale, saturate, slew-limit and cap one wheel speed
    logic signed [SPEED_W-1:0] spd_prev;
    logic signed [SCALE_W-1:0] scaled;
    logic signed [SPEED_W-1:0] v_sat;
    logic signed [CMP_W-1:0]   pv;
    logic signed [CMP_W-1:0]   vv;
    logic signed [CMP_W-1:0]   slew;
    logic signed [CMP_W-1:0]   cap;
    logic signed [CMP_W-1:0]   w;
    logic signed [SPEED_W-1:0] spd_val;

    assign spd_prev = ctrl.spd_right ? right_prev_reg : left_prev_reg;
    assign scaled   = (SCALE_W'(prod) <<< UP_SH) >>> DN_SH;

    always_comb
    begin
        if (scaled > SCALE_W'(SPEED_MAX))
        begin
            v_sat = SPEED_MAX;
        end
        else if (scaled < SCALE_W'(SPEED_MIN))
        begin
            v_sat = SPEED_MIN;
        end
        else
        begin
            v_sat = scaled[SPEED_W-1:0];
        end

        pv   = CMP_W'(spd_prev);
        vv   = CMP_W'(v_sat);
        slew = CMP_W'(cfg_q.slew_limit) << SPEED_FRAC_BITS;
        cap  = CMP_W'(cfg_q.speed_cap) << SPEED_FRAC_BITS;

        priority if (pv - vv >= slew)
        begin
            w = pv - slew;
        end
        else if (vv - pv >= slew)
        begin
            w = pv + slew;
        end
        else
        begin
            w = vv;
        end

        if (w >= cap)
        begin
            w = cap;
        end

        if (w > CMP_W'(SPEED_MAX))
        begin
            spd_val = SPEED_MAX;
        end
        else if (w < CMP_W'(SPEED_MIN))
        begin
            spd_val = SPEED_MIN;
        end
        else
        begin
            spd_val = w[SPEED_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.spd_en && !ctrl.spd_right)
        begin
            ls_reg <= spd_val;
        end
        if (ctrl.spd_en && ctrl.spd_right)
        begin
            rs_reg <= spd_val;
        end
    end

    // Average the speeds and form the saturated error
    logic signed [SPEED_W:0]   spd_sum;
    logic signed [SPEED_W-1:0] avg_val;
    logic signed [EC_W-1:0]    tgt_s;
    logic signed [EC_W-1:0]    e_full;
    logic signed [ERR_W-1:0]   e_val;

    assign spd_sum = (SPEED_W+1)'(ls_reg) + (SPEED_W+1)'(rs_reg);
    assign avg_val = spd_sum[SPEED_W:1];
    assign tgt_s   = EC_W'(tgt_reg) << SPEED_FRAC_BITS;
    assign e_full  = tgt_s - EC_W'(avg_val);

    always_comb
    begin
        if (e_full > EC_W'(ERR_MAX))
        begin
            e_val = ERR_MAX;
        end
        else if (e_full < EC_W'(ERR_MIN))
        begin
            e_val = ERR_MIN;
        end
        else
        begin
            e_val = e_full[ERR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.err_en)
        begin
            avg_reg <= avg_val;
            e_reg   <= e_val;
        end
    end

    // Accumulate the PID products, dropping the integral term at the cutoff
    logic signed [SUM_W-1:0] prod_ext;
    logic signed [SUM_W-1:0] cut;
    logic                    i_drop;
    logic signed [SUM_W-1:0] addend;

    assign prod_ext = SUM_W'(prod);
    assign cut      = SUM_W'(cfg_q.integral_cutoff) << INC_SH;
    assign i_drop   = (prod_ext >= cut) || (prod_ext <= -cut);
    assign addend   = (ctrl.sum_cut && i_drop) ? '0 : prod_ext;

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_load)
        begin
            sum_reg <= prod_ext;
        end
        else if (ctrl.sum_add)
        begin
            sum_reg <= sum_reg + addend;
        end
    end

    // Truncate the increment toward zero and clamp the new drive
    logic signed [SUM_W-1:0]   rnd;
    logic signed [SUM_W-1:0]   inc;
    logic signed [SUM_W-1:0]   acc_full;
    logic signed [SUM_W-1:0]   lim;
    logic signed [SUM_W-1:0]   acc_sat;
    logic signed [DRIVE_W-1:0] drive_val;

    assign rnd      = sum_reg[SUM_W-1] ? SUM_W'({INC_SH{1'b1}}) : '0;
    assign inc      = (sum_reg + rnd) >>> INC_SH;
    assign acc_full = SUM_W'(accum_reg) + inc;
    assign lim      = SUM_W'(cfg_q.drive_limit);

    always_comb
    begin
        if (acc_full > lim)
        begin
            acc_sat = lim;
        end
        else if (acc_full < -lim)
        begin
            acc_sat = -lim;
        end
        else
        begin
            acc_sat = acc_full;
        end
    end

    assign drive_val = acc_sat[DRIVE_W-1:0];

    // Advance the controller state at the end of a tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_prev_reg  <= '0;
            right_prev_reg <= '0;
            last_err_reg   <= '0;
            prior_err_reg  <= '0;
            accum_reg      <= '0;
        end
        else if (ctrl.commit)
        begin
            left_prev_reg  <= ls_reg;
            right_prev_reg <= rs_reg;
            prior_err_reg  <= last_err_reg;
            last_err_reg   <= e_reg;
            accum_reg      <= drive_val;
        end
    end

    // Output register: load on commit, drop once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            drive_out_reg <= drive_val;
            avg_out_reg   <= avg_reg;
            ls_out_reg    <= ls_reg;
            rs_out_reg    <= rs_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.drive         = drive_out_reg;
    assign result.average_speed = avg_out_reg;
    assign result.left_speed    = ls_out_reg;
    assign result.right_speed   = rs_out_reg;

`ifndef SYNTHESIS
    // A tick only finishes into a free output register
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |-> (!out_valid_reg || result.ready))
        else $error("tick committed over an untaken result");

    // The sample port closes right after a sample transfer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("sample port still open while a tick is in progress");

    // Presented average is the floored mean of the presented wheel speeds
    a_avg_match: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((((SPEED_W+1)'(result.left_speed)
                          + (SPEED_W+1)'(result.right_speed)) >>> 1)
                          == (SPEED_W+1)'(result.average_speed)))
        else $error("average speed does not match wheel speeds");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking testbench of the wheel speed incremental PID controller.
module tb;
    import wspid_pkg::*;

    localparam int     FB            = SPEED_FRAC_BITS;
    localparam int     SETTLE_CYCLES = 12;
    localparam int     TAIL_CYCLES   = 20;
    localparam int     CYCLE_LIMIT   = 600000;
    localparam longint SPD_LO        = longint'(SPEED_MIN);
    localparam longint SPD_HI        = longint'(SPEED_MAX);
    localparam longint ERR_LO        = longint'(ERR_MIN);
    localparam longint ERR_HI        = longint'(ERR_MAX);

    // One control tick as seen on the result port
    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic signed [SPEED_W-1:0] average_speed;
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
    } tick_result_t;

    logic clk = 1'b0;
    logic rst_n;

    wspid_in_if  sample_if ();
    wspid_out_if result_if ();
    wspid_cfg_if cfg_if ();

    wheel_speed_incremental_pid uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // Controller state mirrored in the testbench
    cfg_t                      ctl_cfg    = CFG_RESET;
    logic signed [SPEED_W-1:0] left_prev  = '0;
    logic signed [SPEED_W-1:0] right_prev = '0;
    logic signed [ERR_W-1:0]   last_err   = '0;
    logic signed [ERR_W-1:0]   prior_err  = '0;
    logic signed [DRIVE_W-1:0] drive_acc  = '0;

    tick_result_t tick_results_q [$];
    tick_result_t oldest_tick;

    bit gap_enable    = 1'b1;
    bit stall_enable  = 1'b1;
    int walk_count    = 0;
    int ticks_sent    = 0;
    int results_seen  = 0;
    int setting_count = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d ticks pending", cycle_count,
                     tick_results_q.size());
            $display("FAIL wheel_speed_incremental_pid");
            $finish;
        end
    end

    function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // Scale one encoder count, then apply the slew limit and the upper cap
    function automatic longint scale_wheel(input longint count, input longint prev);
        longint raw, v, slew, cap;
        raw = count * longint'(ctl_cfg.count_gain);
        if (FB >= 8)
            v = raw <<< (FB - 8);
        else
            v = raw >>> (8 - FB);
        v = clamp_to(v, SPD_LO, SPD_HI);
        slew = longint'(ctl_cfg.slew_limit) <<< FB;
        if (prev - v >= slew)
            v = prev - slew;
        else if (v - prev >= slew)
            v = prev + slew;
        cap = longint'(ctl_cfg.speed_cap) <<< FB;
        if (v >= cap)
            v = cap;
        return clamp_to(v, SPD_LO, SPD_HI);
    endfunction

    // Advance the mirrored controller by one tick and return its outputs
    function automatic tick_result_t control_tick(input logic signed [COUNT_W-1:0] lcount,
                                                  input logic signed [COUNT_W-1:0] rcount,
                                                  input logic [TARGET_W-1:0] target);
        longint ls, rs, avg, err, p_term, i_term, d_term, cut, pid_sum, inc, acc, lim;
        tick_result_t r;
        ls  = scale_wheel(-longint'(lcount), longint'(left_prev));
        rs  = scale_wheel(longint'(rcount), longint'(right_prev));
        avg = (ls + rs) >>> 1;
        left_prev  = ls[SPEED_W-1:0];
        right_prev = rs[SPEED_W-1:0];

        err    = clamp_to((longint'(target) <<< FB) - avg, ERR_LO, ERR_HI);
        p_term = longint'(ctl_cfg.gain_p) * (err - longint'(last_err));
        i_term = longint'(ctl_cfg.gain_i) * err;
        d_term = longint'(ctl_cfg.gain_d) *
                 (err - 2 * longint'(last_err) + longint'(prior_err));
        // Drop the integral term once it reaches the cutoff
        cut = longint'(ctl_cfg.integral_cutoff) <<< (FB + 8);
        if (i_term >= cut || i_term <= -cut)
            i_term = 0;
        // Truncate toward zero
        pid_sum = p_term + i_term + d_term;
        inc = (pid_sum >= 0) ? (pid_sum >>> (FB + 8)) : -((-pid_sum) >>> (FB + 8));
        prior_err = last_err;
        last_err  = err[ERR_W-1:0];

        lim = longint'(ctl_cfg.drive_limit);
        acc = clamp_to(longint'(drive_acc) + inc, -lim, lim);
        drive_acc = acc[DRIVE_W-1:0];

        r.drive         = acc[DRIVE_W-1:0];
        r.average_speed = avg[SPEED_W-1:0];
        r.left_speed    = ls[SPEED_W-1:0];
        r.right_speed   = rs[SPEED_W-1:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Match every result transfer against the oldest predicted tick
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (tick_results_q.size() == 0)
            begin
                $error("result with no tick pending: drive %0d", result_if.drive);
                fail_count++;
            end
            else
            begin
                oldest_tick = tick_results_q.pop_front();
                compare_field("drive", longint'(oldest_tick.drive),
                              longint'(result_if.drive));
                compare_field("average_speed", longint'(oldest_tick.average_speed),
                              longint'(result_if.average_speed));
                compare_field("left_speed", longint'(oldest_tick.left_speed),
                              longint'(result_if.left_speed));
                compare_field("right_speed", longint'(oldest_tick.right_speed),
                              longint'(result_if.right_speed));
                results_seen++;
            end
        end
    end

    // Result side: stall a random number of cycles before each transfer
    initial
    begin : result_sink
        int stall;
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = stall_enable ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (result_if.valid !== 1'b1);
        end
    end

    // Send one sample; valid stays high afterwards so back-to-back ticks need no dip
    task automatic send_tick(input logic signed [COUNT_W-1:0] lcount,
                             input logic signed [COUNT_W-1:0] rcount,
                             input logic [TARGET_W-1:0] target);
        int gap;
        gap = gap_enable ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            // Half the time, place the gap after the block is ready again
            if ($urandom_range(0, 1) == 1)
                do @(posedge clk); while (sample_if.ready !== 1'b1);
            repeat (gap) @(posedge clk);
        end
        sample_if.valid        <= 1'b1;
        sample_if.left_count   <= lcount;
        sample_if.right_count  <= rcount;
        sample_if.target_speed <= target;
        do @(posedge clk); while (sample_if.ready !== 1'b1);
        tick_results_q.push_back(control_tick(lcount, rcount, target));
        ticks_sent++;
    endtask

    // Hold off the sender until every pending tick has come back
    task automatic wait_drained();
        sample_if.valid <= 1'b0;
        while (tick_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] setting_field(input cfg_t c, input cfg_idx_t idx);
        case (idx)
            REG_COUNT_GAIN:      return CFG_DATA_W'(c.count_gain);
            REG_SLEW_LIMIT:      return CFG_DATA_W'(c.slew_limit);
            REG_SPEED_CAP:       return CFG_DATA_W'(c.speed_cap);
            REG_GAIN_P:          return CFG_DATA_W'(c.gain_p);
            REG_GAIN_I:          return CFG_DATA_W'(c.gain_i);
            REG_GAIN_D:          return CFG_DATA_W'(c.gain_d);
            REG_INTEGRAL_CUTOFF: return CFG_DATA_W'(c.integral_cutoff);
            default:             return CFG_DATA_W'(c.drive_limit);
        endcase
    endfunction

    // Drain the block, then write all eight registers back to back
    task automatic apply_setting(input cfg_t c);
        cfg_idx_t idx;
        wait_drained();
        idx = idx.first();
        cfg_if.valid <= 1'b1;
        do
        begin
            cfg_if.index <= idx;
            cfg_if.data  <= setting_field(c, idx);
            do @(posedge clk); while (cfg_if.ready !== 1'b1);
            idx = idx.next();
        end
        while (idx != idx.first());
        cfg_if.valid <= 1'b0;
        ctl_cfg = c;
        setting_count++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input int width,
                                                             input int dflt);
        int top, near;
        top  = (1 << width) - 1;
        near = (2 * dflt + 64 > top) ? top : 2 * dflt + 64;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return top[CFG_DATA_W-1:0];
            2:       return dflt[CFG_DATA_W-1:0];
            3, 4:    return CFG_DATA_W'($urandom_range(0, top));
            default: return CFG_DATA_W'($urandom_range(0, near));
        endcase
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;
        c.count_gain      = CG_W'(pick_reg_value(CG_W, int'(CFG_RESET.count_gain)));
        c.slew_limit      = SLEW_W'(pick_reg_value(SLEW_W, int'(CFG_RESET.slew_limit)));
        c.speed_cap       = CAP_W'(pick_reg_value(CAP_W, int'(CFG_RESET.speed_cap)));
        c.gain_p          = GAIN_W'(pick_reg_value(GAIN_W, int'(CFG_RESET.gain_p)));
        c.gain_i          = GAIN_W'(pick_reg_value(GAIN_W, int'(CFG_RESET.gain_i)));
        c.gain_d          = GAIN_W'(pick_reg_value(GAIN_W, 256));
        c.integral_cutoff = CUT_W'(pick_reg_value(CUT_W,
                                                  int'(CFG_RESET.integral_cutoff)));
        c.drive_limit     = LIM_W'(pick_reg_value(LIM_W, int'(CFG_RESET.drive_limit)));
        return c;
    endfunction

    // Mostly a drifting wheel pair at realistic speeds, plus noise and corner counts
    task automatic send_random_tick();
        int pick, step;
        logic signed [COUNT_W-1:0] lc, rc;
        logic [TARGET_W-1:0] tgt;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            step = $urandom_range(0, 80);
            walk_count = walk_count + step - 40;
            if (walk_count > 3000)
                walk_count = 3000;
            if (walk_count < -3000)
                walk_count = -3000;
            step = $urandom_range(0, 20);
            lc = COUNT_W'(-(walk_count + step - 10));
            step = $urandom_range(0, 20);
            rc = COUNT_W'(walk_count + step - 10);
            tgt = TARGET_W'($urandom_range(0, 400));
        end
        else if (pick < 90)
        begin
            lc  = COUNT_W'($urandom);
            rc  = COUNT_W'($urandom);
            tgt = TARGET_W'($urandom);
        end
        else
        begin
            lc  = ($urandom_range(0, 1) == 1) ? 16'sh8000 : 16'sh7FFF;
            rc  = ($urandom_range(0, 1) == 1) ? 16'sh0000 : 16'shFFFF;
            tgt = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        end
        send_tick(lc, rc, tgt);
    endtask

    // Default registers: field extremes, bit patterns, slew ramp, cutoff on and off
    task automatic test_reset_settings();
        send_tick(16'sh0000, 16'sh0000, 16'h0000);
        send_tick(16'sh8000, 16'sh7FFF, 16'hFFFF);
        send_tick(16'sh7FFF, 16'sh8000, 16'h0000);
        send_tick(16'sh5555, 16'shAAAA, 16'h5555);
        send_tick(16'shAAAA, 16'sh5555, 16'hAAAA);
        send_tick(-16'sd40, 16'sd40, 16'd100);
        send_tick(-16'sd40, 16'sd40, 16'd100);
        send_tick(-16'sd40, 16'sd40, 16'd100);
        send_tick(16'sd0, 16'sd0, 16'd100);
    endtask

    // Every register at its maximum: speeds saturate, drive hits the wide clamp
    task automatic test_extreme_settings();
        cfg_t c;
        c.count_gain      = '1;
        c.slew_limit      = '1;
        c.speed_cap       = '1;
        c.gain_p          = '1;
        c.gain_i          = '1;
        c.gain_d          = '1;
        c.integral_cutoff = '1;
        c.drive_limit     = '1;
        apply_setting(c);
        send_tick(16'sh8000, 16'sh8000, 16'hFFFF);
        send_tick(16'sh7FFF, 16'sh7FFF, 16'h0000);
        send_tick(16'sh0000, 16'sh0000, 16'hFFFF);
        send_tick(16'sh8000, 16'sh7FFF, 16'h0001);
        send_tick(16'shFFFF, 16'sh0001, 16'hFFFF);
    endtask

    // Zero slew holds speeds, zero cap clips only positive speeds,
    // zero cutoff kills the integral term, zero limit pins the drive
    task automatic test_zero_settings();
        cfg_t c;
        c = '0;
        c.count_gain = 16'd256;
        c.gain_i     = '1;
        apply_setting(c);
        send_tick(-16'sd100, 16'sd100, 16'h0000);
        send_tick(16'sd100, -16'sd100, 16'hFFFF);
        send_tick(16'sd0, 16'sd0, 16'd300);
    endtask

    // Default registers again, with one full drain in the middle of the traffic
    task automatic test_drain_pause();
        apply_setting(CFG_RESET);
        repeat (100) send_random_tick();
        wait_drained();
        repeat (100) send_random_tick();
    endtask

    // Random register settings with different idling mixes per phase
    task automatic test_random_settings();
        for (int phase = 0; phase < 7; phase++)
        begin
            apply_setting(random_setting());
            gap_enable   = (phase % 4 == 0) || (phase % 4 == 2);
            stall_enable = (phase % 4 == 0) || (phase % 4 == 1);
            repeat (250) send_random_tick();
        end
        gap_enable   = 1'b1;
        stall_enable = 1'b1;
    endtask

    initial
    begin : run_sequence
        rst_n                  <= 1'b0;
        sample_if.valid        <= 1'b0;
        sample_if.left_count   <= '0;
        sample_if.right_count  <= '0;
        sample_if.target_speed <= '0;
        cfg_if.valid           <= 1'b0;
        cfg_if.index           <= REG_COUNT_GAIN;
        cfg_if.data            <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_extreme_settings();
        test_zero_settings();
        test_drain_pause();
        test_random_settings();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d control ticks across %0d register settings", ticks_sent,
                 setting_count + 1);
        $display("Compared %0d results, %0d mismatches", results_seen, fail_count);
        if (fail_count == 0)
            $display("PASS wheel_speed_incremental_pid");
        else
            $display("FAIL wheel_speed_incremental_pid");
        $finish;
    end
endmodule
